>>> hw/rtl/blp_pkg.sv
// Shared types and constants for the bitmask longest path core.
// No dependencies; imported by every module of the block.
package blp_pkg;

  localparam int MAX_NODES_DEF = 8;
  localparam int NODE_CNT_W    = 4;
  localparam int NODE_W        = 3;
  localparam int WEIGHT_W      = 30;
  localparam int BEST_W        = 33;

  localparam logic [NODE_CNT_W-1:0] NODE_COUNT_RST = 4'd8;
  localparam logic [BEST_W-1:0]     BEST_MAX       = '1;

  localparam logic ACT_EDGE = 1'b0;
  localparam logic ACT_RUN  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } blp_state_e;

  typedef struct packed {
    logic edge_load;
    logic edge_store;
    logic dp_start;
    logic dp_step;
    logic finish;
  } blp_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic issue_last;
    logic out_free;
  } blp_stat_t;

endpackage

>>> hw/rtl/blp_ctrl.sv
// Controller state machine of the bitmask longest path core.
// Depends on blp_pkg; drives the datapath commands in blp_dp.
module blp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              action_i,
  input  blp_pkg::blp_stat_t stat_i,
  output logic              in_ready_o,
  output blp_pkg::blp_cmd_t cmd_o
);
  import blp_pkg::*;

  blp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (action_i == ACT_RUN) begin
            state_d = stat_i.n_zero ? ST_FINISH : ST_RUN;
          end else begin
            state_d = ST_EDGE;
          end
        end
      end
      ST_EDGE: state_d = ST_IDLE;
      ST_RUN: begin
        if (stat_i.issue_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_FINISH;
      ST_FINISH: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.edge_load = in_valid_i && (action_i == ACT_EDGE);
        cmd_o.dp_start  = in_valid_i && (action_i == ACT_RUN);
      end
      ST_EDGE:   cmd_o.edge_store = 1'b1;
      ST_RUN:    cmd_o.dp_step    = 1'b1;
      ST_DRAIN:  cmd_o            = '0;
      ST_FINISH: cmd_o.finish     = stat_i.out_free;
      default:   cmd_o            = '0;
    endcase
  end

endmodule

>>> hw/rtl/blp_dp.sv
// Datapath of the bitmask longest path core: edge table, subset DP memory,
// loop counters, two-stage relax pipeline and result register. Uses blp_pkg.
module blp_dp #(
  parameter int MaxNodes = blp_pkg::MAX_NODES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  blp_pkg::blp_cmd_t               cmd_i,
  output blp_pkg::blp_stat_t              stat_o,
  input  logic                            cfg_we_i,
  input  logic [blp_pkg::NODE_CNT_W-1:0]  cfg_wdata_i,
  input  logic [blp_pkg::NODE_W-1:0]      node_a_i,
  input  logic [blp_pkg::NODE_W-1:0]      node_b_i,
  input  logic [blp_pkg::WEIGHT_W-1:0]    weight_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [blp_pkg::BEST_W-1:0]      best_length_o
);
  import blp_pkg::*;

  localparam int NodeW     = $clog2(MaxNodes);
  localparam int CntW      = $clog2(MaxNodes + 1);
  localparam int SlotDepth = MaxNodes * MaxNodes;
  localparam int SlotW     = $clog2(SlotDepth);
  localparam int SumW      = WEIGHT_W + $clog2(MaxNodes);
  localparam int PathDepth = MaxNodes << MaxNodes;
  localparam int PathAw    = NodeW + MaxNodes;

  function automatic logic [SlotW-1:0] slot_of(logic [NodeW-1:0] x, logic [NodeW-1:0] y);
    logic [NodeW-1:0] lo;
    logic [NodeW-1:0] hi;
    lo = (x < y) ? x : y;
    hi = (x < y) ? y : x;
    return SlotW'(lo) * SlotW'(MaxNodes) + SlotW'(hi);
  endfunction

  // configuration
  logic [NODE_CNT_W-1:0] node_count_q;
  logic [CntW-1:0]       n;
  logic [NodeW-1:0]      n_last;
  logic [MaxNodes-1:0]   mask_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
    end else if (cfg_we_i) begin
      node_count_q <= cfg_wdata_i;
    end
  end

  assign n         = (int'(node_count_q) > MaxNodes) ? CntW'(MaxNodes) : CntW'(node_count_q);
  assign n_last    = NodeW'(n - CntW'(1));
  assign mask_last = ~({MaxNodes{1'b1}} << n);

  // edge table
  logic [WEIGHT_W-1:0]  wmem [SlotDepth];
  logic [WEIGHT_W-1:0]  w_rd_q;
  logic [SlotW-1:0]     w_raddr;
  logic                 w_we;
  logic [SlotDepth-1:0] present_q;
  logic [NodeW-1:0]     in_a, in_b;
  logic                 in_ok;
  logic [SlotW-1:0]     e_slot_q;
  logic [WEIGHT_W-1:0]  e_w_q;
  logic                 e_ok_q;

  // DP loop counters
  logic [MaxNodes-1:0] mask_q;
  logic [NodeW-1:0]    k_q, j_q;
  logic                j_last, k_last;
  logic [MaxNodes-1:0] kbit, jbit, m_minus;
  logic                kin, jin, use_edge;

  assign in_a  = NodeW'(node_a_i);
  assign in_b  = NodeW'(node_b_i);
  assign in_ok = (int'(node_a_i) < MaxNodes) && (int'(node_b_i) < MaxNodes);

  assign w_raddr = cmd_i.edge_load ? slot_of(in_a, in_b) : slot_of(j_q, k_q);
  assign w_we    = cmd_i.edge_store && e_ok_q && (!present_q[e_slot_q] || (w_rd_q < e_w_q));

  always_ff @(posedge clk_i) begin
    w_rd_q <= wmem[w_raddr];
    if (w_we) begin
      wmem[e_slot_q] <= e_w_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.edge_load) begin
      e_slot_q <= slot_of(in_a, in_b);
      e_w_q    <= weight_i;
      e_ok_q   <= in_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
    end else if (cmd_i.finish) begin
      present_q <= '0;
    end else if (w_we) begin
      present_q[e_slot_q] <= 1'b1;
    end
  end

  assign j_last = (j_q == n_last);
  assign k_last = (k_q == n_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      k_q    <= '0;
      j_q    <= '0;
    end else if (cmd_i.dp_start) begin
      mask_q <= MaxNodes'(1);
      k_q    <= '0;
      j_q    <= '0;
    end else if (cmd_i.dp_step) begin
      if (j_last) begin
        j_q <= '0;
        if (k_last) begin
          k_q    <= '0;
          mask_q <= mask_q + MaxNodes'(1);
        end else begin
          k_q <= k_q + NodeW'(1);
        end
      end else begin
        j_q <= j_q + NodeW'(1);
      end
    end
  end

  assign kbit     = MaxNodes'(1) << k_q;
  assign jbit     = MaxNodes'(1) << j_q;
  assign kin      = |(mask_q & kbit);
  assign jin      = |(mask_q & jbit);
  assign m_minus  = mask_q & ~kbit;
  assign use_edge = jin && kin && (j_q != k_q) && present_q[slot_of(j_q, k_q)];

  // path memory: {reached, best} per (end node, visited mask)
  logic [SumW:0]       pmem [PathDepth];
  logic [SumW:0]       p_rd_q;
  logic [PathAw-1:0]   p_raddr;
  logic                p_we;

  // relax stage
  logic                s1_valid_q;
  logic                s1_use_q, s1_kin_q, s1_single_q, s1_first_q, s1_last_q;
  logic [NodeW-1:0]    s1_k_q;
  logic [MaxNodes-1:0] s1_mask_q;
  logic [SumW:0]       acc_q, acc_in, acc_new;
  logic [SumW-1:0]     cand;
  logic                cand_ok;
  logic [SumW-1:0]     best_q;

  assign p_raddr = {j_q, m_minus};

  always_ff @(posedge clk_i) begin
    p_rd_q <= pmem[p_raddr];
    if (p_we) begin
      pmem[{s1_k_q, s1_mask_q}] <= acc_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.dp_step;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_use_q    <= use_edge;
    s1_kin_q    <= kin;
    s1_single_q <= kin && (m_minus == '0);
    s1_first_q  <= (j_q == '0);
    s1_last_q   <= j_last;
    s1_k_q      <= k_q;
    s1_mask_q   <= mask_q;
  end

  assign cand    = p_rd_q[SumW-1:0] + SumW'(w_rd_q);
  assign cand_ok = s1_use_q && p_rd_q[SumW];
  assign acc_in  = s1_first_q ? {s1_single_q, {SumW{1'b0}}} : acc_q;
  assign acc_new = (cand_ok && (!acc_in[SumW] || (acc_in[SumW-1:0] < cand)))
                   ? {1'b1, cand} : acc_in;
  assign p_we    = s1_valid_q && s1_last_q && s1_kin_q;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      acc_q <= acc_new;
    end
    if (cmd_i.dp_start) begin
      best_q <= '0;
    end else if (p_we && acc_new[SumW] && (acc_new[SumW-1:0] > best_q)) begin
      best_q <= acc_new[SumW-1:0];
    end
  end

  // result register
  logic              out_valid_q;
  logic [BEST_W-1:0] best_length_q;
  logic [BEST_W-1:0] best_sat;

  assign best_sat = (best_q > SumW'(BEST_MAX)) ? BEST_MAX : BEST_W'(best_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      best_length_q <= best_sat;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign best_length_o = best_length_q;

  assign stat_o.n_zero     = (n == '0);
  assign stat_o.issue_last = j_last && k_last && (mask_q == mask_last);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

endmodule

>>> hw/rtl/bitmask_longest_path_core.sv
// Bitmask longest path core: heaviest simple path in a small weighted graph.
// Input channel (in_valid_i/in_ready_o) carries action_i, node_a_i, node_b_i
// and weight_i. An edge item (action 0) stores the pair in both directions,
// keeping the larger weight, and gives no result. A run item (action 1)
// walks the subset DP over (visited mask, end node) and pushes one
// best_length_o on the output channel (out_valid_o/out_ready_i), then
// clears the edge table. The DP loop issues one (mask, end node,
// predecessor) triple per cycle through the single-read path memory;
// with n = 0 active nodes the run skips the DP loop and answers 0.
// The output register holds a finished result while new edge items are
// accepted; a further run waits in its last cycle until the result is taken.
// cfg_we_i/cfg_wdata_i write node_count (reset 8, clamped to MaxNodes); write
// only while idle. Reset clears control state, the edge table and the output;
// no clearing pass is needed since every DP entry is written before it is read.
module bitmask_longest_path_core #(
  parameter int MaxNodes = blp_pkg::MAX_NODES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [blp_pkg::NODE_CNT_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           action_i,
  input  logic [blp_pkg::NODE_W-1:0]     node_a_i,
  input  logic [blp_pkg::NODE_W-1:0]     node_b_i,
  input  logic [blp_pkg::WEIGHT_W-1:0]   weight_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [blp_pkg::BEST_W-1:0]     best_length_o
);
  import blp_pkg::*;

  blp_cmd_t  cmd;
  blp_stat_t stat;

  blp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  blp_dp #(
    .MaxNodes (MaxNodes)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .node_a_i      (node_a_i),
    .node_b_i      (node_b_i),
    .weight_i      (weight_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .best_length_o (best_length_o)
  );

endmodule

>>> hw/rtl/blp_checker.sv
// Port-level checks for bitmask_longest_path_core, attached by bind.
// Depends on blp_pkg.
module blp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           action_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [blp_pkg::BEST_W-1:0]     best_length_o
);
  import blp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(best_length_o))
    else $error("result dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while previous item still in work");

  a_edge_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (action_i == ACT_EDGE) && !out_valid_o |=> !out_valid_o)
    else $error("edge item produced a result");

  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without a run in progress");

endmodule

bind bitmask_longest_path_core blp_checker u_blp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .action_i      (action_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .best_length_o (best_length_o)
);
